/* rtl/core/fmrc_pkg.sv */
// Shared types, constants and codes for the filament motion ratio checker.
`timescale 1ns / 1ps

package fmrc_pkg;

    localparam int AMOUNT_BITS_DEF     = 24;
    localparam int TOTAL_BITS_DEF      = 40;
    localparam int RATIO_FRAC_BITS_DEF = 12;

    localparam int RATIO_BITS    = 18;
    localparam int CAL_BITS      = 16;
    localparam int CAL_FRAC_BITS = 12;
    localparam int LIMIT_BITS    = 17;
    localparam int MODE_BITS     = 2;
    localparam int CODE_BITS     = 2;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int CAL_LENGTH_UM = 10000;

    localparam logic [CAL_BITS-1:0]   CAL_FACTOR_RST = 16'd4096;
    localparam logic [LIMIT_BITS-1:0] MIN_RATIO_RST  = 17'd2458;
    localparam logic [LIMIT_BITS-1:0] MAX_RATIO_RST  = 17'd6144;
    localparam logic [MODE_BITS-1:0]  MODE_OFF       = 2'd0;

    typedef enum logic [1:0] {
        REG_CAL_FACTOR,
        REG_MIN_RATIO,
        REG_MAX_RATIO,
        REG_ENABLE_MODE
    } t_reg_idx;

    typedef enum logic [CODE_BITS-1:0] {
        STS_OK,
        STS_NO_DATA,
        STS_TOO_LITTLE,
        STS_TOO_MUCH
    } t_status;

    typedef enum logic [CODE_BITS-1:0] {
        PH_IDLE,
        PH_CAL,
        PH_CMP
    } t_phase;

    typedef enum logic {
        OP_CHECK,
        OP_RESTART
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_SUM,
        S_CAL,
        S_DIVCHK,
        S_DIV,
        S_APPLY,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [CAL_BITS-1:0]   cal_factor;
        logic [LIMIT_BITS-1:0] min_ratio;
        logic [LIMIT_BITS-1:0] max_ratio;
        logic [MODE_BITS-1:0]  mode;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic scale;
        logic sum;
        logic cal;
        logic div_start;
        logic div_step;
        logic apply;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic   skip;
        t_phase phase;
        logic   cal_hit;
        logic   div_done;
        logic   out_busy;
    } t_stat;

endpackage

/* rtl/core/fmrc_if.sv */
// Segment report and result channel interfaces.
`timescale 1ns / 1ps

interface fmrc_seg_if #(
    parameter int AMOUNT_BITS = fmrc_pkg::AMOUNT_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [AMOUNT_BITS-1:0] amount_commanded;
    logic signed [AMOUNT_BITS-1:0] amount_measured;
    logic                          sensor_has_data;

    modport source (
        output valid, operation, amount_commanded, amount_measured, sensor_has_data,
        input  ready
    );
    modport sink (
        input  valid, operation, amount_commanded, amount_measured, sensor_has_data,
        output ready
    );
endinterface

interface fmrc_res_if #(
    parameter int TOTAL_BITS = fmrc_pkg::TOTAL_BITS_DEF
) ();
    logic                                    valid;
    logic                                    ready;
    logic [fmrc_pkg::CODE_BITS-1:0]          status;
    logic [fmrc_pkg::CODE_BITS-1:0]          phase;
    logic signed [fmrc_pkg::RATIO_BITS-1:0]  last_ratio;
    logic signed [fmrc_pkg::RATIO_BITS-1:0]  lowest_ratio;
    logic signed [fmrc_pkg::RATIO_BITS-1:0]  highest_ratio;
    logic signed [TOTAL_BITS-1:0]            total_commanded;

    modport source (
        output valid, status, phase, last_ratio, lowest_ratio, highest_ratio,
               total_commanded,
        input  ready
    );
    modport sink (
        input  valid, status, phase, last_ratio, lowest_ratio, highest_ratio,
               total_commanded,
        output ready
    );
endinterface

/* rtl/core/filament_motion_ratio_checker.sv */
// Filament motion ratio checker: top level.
//
// One segment report enters on i_seg (valid/ready), one result leaves on
// o_res (valid/ready) for every report taken. Configuration is written over
// the APB port: calibration factor at 0x0, min ratio at 0x4, max ratio at
// 0x8, enable mode at 0xC; pready is always high.
// A comparing report goes through multiply, round, sum, divider setup, an
// 18-step shift-subtract divider that produces one quotient bit per cycle,
// ratio update and output load. The report that completes calibration also
// passes the calibration check. Restart reports and reports without sensor
// data go from multiply straight to output load; the first report from idle
// goes to output load after the sum, a calibration report below 10 mm after
// the calibration check. One report is worked on at a time; i_seg.ready is
// high only while the sequencer is idle, so the next transfer can come only
// once the result is loaded. Results sit in an output register, so the next
// report is taken while a result waits; if the receiver still stalls when
// the next result is done, the sequencer holds until the register frees up.
// Reset (synchronous, active low) returns the phase to idle, clears sums,
// ratios and direction, and loads the register defaults.
`timescale 1ns / 1ps

module filament_motion_ratio_checker #(
    parameter int AMOUNT_BITS     = fmrc_pkg::AMOUNT_BITS_DEF,
    parameter int TOTAL_BITS      = fmrc_pkg::TOTAL_BITS_DEF,
    parameter int RATIO_FRAC_BITS = fmrc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fmrc_seg_if.sink                           i_seg,
    fmrc_res_if.source                         o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fmrc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fmrc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fmrc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import fmrc_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    fmrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fmrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seg.valid),
        .o_ready (i_seg.ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    fmrc_dp #(
        .AMOUNT_BITS     (AMOUNT_BITS),
        .TOTAL_BITS      (TOTAL_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_cfg              (w_cfg),
        .i_operation        (i_seg.operation),
        .i_amount_commanded (i_seg.amount_commanded),
        .i_amount_measured  (i_seg.amount_measured),
        .i_sensor_has_data  (i_seg.sensor_has_data),
        .i_out_ready        (o_res.ready),
        .o_out_valid        (o_res.valid),
        .o_status           (o_res.status),
        .o_phase            (o_res.phase),
        .o_last_ratio       (o_res.last_ratio),
        .o_lowest_ratio     (o_res.lowest_ratio),
        .o_highest_ratio    (o_res.highest_ratio),
        .o_total_commanded  (o_res.total_commanded)
    );

endmodule

/* rtl/core/fmrc_regs.sv */
// APB configuration register file.
`timescale 1ns / 1ps

module fmrc_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fmrc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fmrc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fmrc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output fmrc_pkg::t_cfg                     o_cfg
);
    import fmrc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_factor <= CAL_FACTOR_RST;
            r_cfg.min_ratio  <= MIN_RATIO_RST;
            r_cfg.max_ratio  <= MAX_RATIO_RST;
            r_cfg.mode       <= MODE_OFF;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CAL_FACTOR:  r_cfg.cal_factor <= pwdata[CAL_BITS-1:0];
                REG_MIN_RATIO:   r_cfg.min_ratio  <= pwdata[LIMIT_BITS-1:0];
                REG_MAX_RATIO:   r_cfg.max_ratio  <= pwdata[LIMIT_BITS-1:0];
                REG_ENABLE_MODE: r_cfg.mode       <= pwdata[MODE_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CAL_FACTOR:  prdata = APB_DATA_BITS'(r_cfg.cal_factor);
            REG_MIN_RATIO:   prdata = APB_DATA_BITS'(r_cfg.min_ratio);
            REG_MAX_RATIO:   prdata = APB_DATA_BITS'(r_cfg.max_ratio);
            REG_ENABLE_MODE: prdata = APB_DATA_BITS'(r_cfg.mode);
        endcase
    end

endmodule

/* rtl/core/fmrc_ctrl.sv */
// Sequencing state machine for one segment report.
`timescale 1ns / 1ps

module fmrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fmrc_pkg::t_stat i_stat,
    output fmrc_pkg::t_cmd  o_cmd
);
    import fmrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_MUL;
            S_MUL:    n_state = i_stat.skip ? S_PUSH : S_SCALE;
            S_SCALE:  n_state = S_SUM;
            S_SUM: begin
                case (i_stat.phase)
                    PH_CMP:  n_state = S_DIVCHK;
                    PH_CAL:  n_state = S_CAL;
                    default: n_state = S_PUSH;
                endcase
            end
            S_CAL:    n_state = i_stat.cal_hit ? S_DIVCHK : S_PUSH;
            S_DIVCHK: n_state = S_DIV;
            S_DIV:    if (i_stat.div_done) n_state = S_APPLY;
            S_APPLY:  n_state = S_PUSH;
            S_PUSH:   if (!i_stat.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_MUL:    o_cmd.mul       = 1'b1;
            S_SCALE:  o_cmd.scale     = 1'b1;
            S_SUM:    o_cmd.sum       = 1'b1;
            S_CAL:    o_cmd.cal       = 1'b1;
            S_DIVCHK: o_cmd.div_start = 1'b1;
            S_DIV:    o_cmd.div_step  = 1'b1;
            S_APPLY:  o_cmd.apply     = 1'b1;
            S_PUSH:   o_cmd.push      = !i_stat.out_busy;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

/* rtl/core/fmrc_dp.sv */
// Datapath: scaling, saturating sums, shift-subtract ratio divider, result register.
`timescale 1ns / 1ps

module fmrc_dp #(
    parameter int AMOUNT_BITS     = fmrc_pkg::AMOUNT_BITS_DEF,
    parameter int TOTAL_BITS      = fmrc_pkg::TOTAL_BITS_DEF,
    parameter int RATIO_FRAC_BITS = fmrc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fmrc_pkg::t_cmd                         i_cmd,
    output fmrc_pkg::t_stat                        o_stat,
    input  fmrc_pkg::t_cfg                         i_cfg,
    input  logic                                   i_operation,
    input  logic signed [AMOUNT_BITS-1:0]          i_amount_commanded,
    input  logic signed [AMOUNT_BITS-1:0]          i_amount_measured,
    input  logic                                   i_sensor_has_data,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [fmrc_pkg::CODE_BITS-1:0]         o_status,
    output logic [fmrc_pkg::CODE_BITS-1:0]         o_phase,
    output logic signed [fmrc_pkg::RATIO_BITS-1:0] o_last_ratio,
    output logic signed [fmrc_pkg::RATIO_BITS-1:0] o_lowest_ratio,
    output logic signed [fmrc_pkg::RATIO_BITS-1:0] o_highest_ratio,
    output logic signed [TOTAL_BITS-1:0]           o_total_commanded
);
    import fmrc_pkg::*;

    localparam int PROD_BITS = AMOUNT_BITS + CAL_BITS + 1;
    localparam int RND_BITS  = PROD_BITS - CAL_FRAC_BITS;
    localparam int SCL_BITS  = RND_BITS + 1;
    localparam int NUM_BITS  = (TOTAL_BITS > SCL_BITS) ? TOTAL_BITS : SCL_BITS;
    localparam int EXT_BITS  = NUM_BITS + 1;
    localparam int DVD_BITS  = NUM_BITS + RATIO_FRAC_BITS;
    localparam int LIM_BITS  = TOTAL_BITS + RATIO_BITS;
    localparam int CMP_BITS  = ((DVD_BITS > LIM_BITS) ? DVD_BITS : LIM_BITS) + 1;
    localparam int CNT_BITS  = $clog2(RATIO_BITS);

    localparam logic [CNT_BITS-1:0]   CNT_LAST = CNT_BITS'(RATIO_BITS - 1);
    localparam logic [RATIO_BITS-1:0] Q_POS_MAX = {1'b0, {(RATIO_BITS-1){1'b1}}};
    localparam logic [RATIO_BITS-1:0] Q_NEG_MAX = {1'b1, {(RATIO_BITS-1){1'b0}}};
    localparam logic [PROD_BITS-1:0]  RND_HALF  = PROD_BITS'(1) << (CAL_FRAC_BITS - 1);

    // architectural state
    t_phase                        r_phase;
    t_phase                        r_prev;
    logic signed [TOTAL_BITS-1:0]  r_sc;
    logic signed [TOTAL_BITS-1:0]  r_sm;
    logic                          r_rev;
    logic signed [RATIO_BITS-1:0]  r_last;
    logic signed [RATIO_BITS-1:0]  r_low;
    logic signed [RATIO_BITS-1:0]  r_high;
    logic                          r_out_valid;
    logic [CNT_BITS-1:0]           r_cnt;

    // working registers
    t_op                           r_op;
    logic                          r_has;
    logic signed [AMOUNT_BITS-1:0] r_cmd;
    logic signed [AMOUNT_BITS-1:0] r_meas;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [SCL_BITS-1:0]    r_scl;
    logic [CMP_BITS-1:0]           r_rem;
    logic [CMP_BITS-1:0]           r_dsh;
    logic [RATIO_BITS-1:0]         r_q;
    logic                          r_ovf;
    logic                          r_dzero;
    logic                          r_nzero;
    logic                          r_nneg;
    logic                          r_neg;

    logic [CODE_BITS-1:0]          r_out_status;
    logic [CODE_BITS-1:0]          r_out_phase;
    logic signed [RATIO_BITS-1:0]  r_out_last;
    logic signed [RATIO_BITS-1:0]  r_out_low;
    logic signed [RATIO_BITS-1:0]  r_out_high;
    logic signed [TOTAL_BITS-1:0]  r_out_total;

    logic signed [PROD_BITS-1:0]   w_prod;
    logic [PROD_BITS-1:0]          w_pmag;
    logic [PROD_BITS-1:0]          w_prnd;
    logic signed [SCL_BITS-1:0]    w_smag;
    logic signed [SCL_BITS-1:0]    w_scl;
    logic signed [EXT_BITS-1:0]    w_sc_x;
    logic signed [EXT_BITS-1:0]    w_sm_x;
    logic signed [EXT_BITS-1:0]    w_cmd_x;
    logic signed [EXT_BITS-1:0]    w_scl_x;
    logic signed [EXT_BITS-1:0]    w_mdir_x;
    logic signed [NUM_BITS-1:0]    w_num;
    logic signed [TOTAL_BITS-1:0]  w_den;
    logic [NUM_BITS-1:0]           w_nmag;
    logic [TOTAL_BITS-1:0]         w_dmag;
    logic [CMP_BITS-1:0]           w_dvd;
    logic [CMP_BITS-1:0]           w_dlim;
    logic                          w_ge;
    logic signed [RATIO_BITS-1:0]  w_ratio;
    logic                          w_cal_hit;
    t_status                       w_status;
    logic signed [RATIO_BITS:0]    w_last_x;
    logic signed [RATIO_BITS:0]    w_min_x;
    logic signed [RATIO_BITS:0]    w_max_x;

    function automatic logic signed [TOTAL_BITS-1:0] f_sat(
        input logic signed [EXT_BITS-1:0] x
    );
        logic signed [EXT_BITS-1:0] hi;
        logic signed [EXT_BITS-1:0] lo;
        hi = {{(EXT_BITS-TOTAL_BITS+1){1'b0}}, {(TOTAL_BITS-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[TOTAL_BITS-1:0];
        end else if (x < lo) begin
            return lo[TOTAL_BITS-1:0];
        end
        return x[TOTAL_BITS-1:0];
    endfunction

    // scaling: measured * factor, round half away from zero
    assign w_prod = PROD_BITS'(r_meas) * $signed({{(PROD_BITS-CAL_BITS){1'b0}}, i_cfg.cal_factor});
    assign w_pmag = r_prod[PROD_BITS-1] ? (~r_prod + 1'b1) : r_prod;
    assign w_prnd = (w_pmag + RND_HALF) >> CAL_FRAC_BITS;
    assign w_smag = $signed({1'b0, w_prnd[RND_BITS-1:0]});
    assign w_scl  = r_prod[PROD_BITS-1] ? -w_smag : w_smag;

    assign w_sc_x   = EXT_BITS'(r_sc);
    assign w_sm_x   = EXT_BITS'(r_sm);
    assign w_cmd_x  = EXT_BITS'(r_cmd);
    assign w_scl_x  = EXT_BITS'(r_scl);
    assign w_mdir_x = r_rev ? -w_scl_x : w_scl_x;

    assign w_cal_hit = r_sc >= $signed(TOTAL_BITS'(CAL_LENGTH_UM));

    // divider operands: calibration uses the sums, comparing uses the segment
    assign w_num  = (r_prev == PH_CMP) ? NUM_BITS'(r_scl) : NUM_BITS'(r_sm);
    assign w_den  = (r_prev == PH_CMP) ? TOTAL_BITS'(r_cmd) : r_sc;
    assign w_nmag = w_num[NUM_BITS-1] ? (~w_num + 1'b1) : w_num;
    assign w_dmag = w_den[TOTAL_BITS-1] ? (~w_den + 1'b1) : w_den;
    assign w_dvd  = CMP_BITS'(w_nmag) << RATIO_FRAC_BITS;
    assign w_dlim = CMP_BITS'(w_dmag) << RATIO_BITS;
    assign w_ge   = r_rem >= r_dsh;

    always_comb begin
        if (r_dzero) begin
            w_ratio = r_nzero ? '0 : (r_nneg ? $signed(Q_NEG_MAX) : $signed(Q_POS_MAX));
        end else if (r_neg) begin
            w_ratio = (r_ovf || (r_q > Q_NEG_MAX)) ? $signed(Q_NEG_MAX) : $signed(~r_q + 1'b1);
        end else begin
            w_ratio = (r_ovf || (r_q > Q_POS_MAX)) ? $signed(Q_POS_MAX) : $signed(r_q);
        end
    end

    assign w_last_x = (RATIO_BITS+1)'(r_last);
    assign w_min_x  = $signed({{(RATIO_BITS+1-LIMIT_BITS){1'b0}}, i_cfg.min_ratio});
    assign w_max_x  = $signed({{(RATIO_BITS+1-LIMIT_BITS){1'b0}}, i_cfg.max_ratio});

    always_comb begin
        w_status = STS_OK;
        if (r_op == OP_RESTART) begin
            w_status = STS_OK;
        end else if (!r_has) begin
            w_status = STS_NO_DATA;
        end else if (r_phase == PH_CMP) begin
            if (w_last_x < w_min_x) begin
                w_status = STS_TOO_LITTLE;
            end else if (w_last_x > w_max_x) begin
                w_status = STS_TOO_MUCH;
            end
        end
        if (i_cfg.mode == MODE_OFF) begin
            w_status = STS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_prev      <= PH_IDLE;
            r_sc        <= '0;
            r_sm        <= '0;
            r_rev       <= 1'b0;
            r_last      <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.load && i_operation) begin
                r_phase <= PH_IDLE;
                r_last  <= '0;
            end
            if (i_cmd.sum) begin
                r_prev <= r_phase;
                case (r_phase)
                    PH_CAL: begin
                        r_sc <= f_sat(w_sc_x + w_cmd_x);
                        r_sm <= f_sat(w_sm_x + w_scl_x);
                    end
                    PH_CMP: begin
                        r_sc <= f_sat(w_sc_x + w_cmd_x);
                        r_sm <= f_sat(w_sm_x + w_mdir_x);
                    end
                    default: begin
                        r_phase <= PH_CAL;
                        r_sc    <= f_sat(w_cmd_x);
                        r_sm    <= f_sat(w_scl_x);
                    end
                endcase
            end
            if (i_cmd.cal && w_cal_hit) begin
                r_rev <= r_sm[TOTAL_BITS-1];
                if (r_sm[TOTAL_BITS-1]) begin
                    r_sm <= f_sat(-w_sm_x);
                end
            end
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.apply) begin
                r_last <= w_ratio;
                if (r_prev == PH_CAL) begin
                    r_low   <= w_ratio;
                    r_high  <= w_ratio;
                    r_phase <= PH_CMP;
                end else if (w_ratio > r_high) begin
                    r_high <= w_ratio;
                end else if (w_ratio < r_low) begin
                    r_low <= w_ratio;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_operation);
            r_has  <= i_sensor_has_data;
            r_cmd  <= i_amount_commanded;
            r_meas <= i_amount_measured;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.scale) begin
            r_scl <= w_scl;
        end
        // keep the direction-corrected segment measurement as the numerator
        if (i_cmd.sum && (r_phase == PH_CMP)) begin
            r_scl <= w_mdir_x[SCL_BITS-1:0];
        end
        if (i_cmd.div_start) begin
            r_rem   <= w_dvd;
            r_dsh   <= w_dlim >> 1;
            r_ovf   <= w_dvd >= w_dlim;
            r_dzero <= (w_dmag == '0);
            r_nzero <= (w_nmag == '0);
            r_nneg  <= w_num[NUM_BITS-1];
            r_neg   <= w_num[NUM_BITS-1] != w_den[TOTAL_BITS-1];
            r_q     <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[RATIO_BITS-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.push) begin
            r_out_status <= w_status;
            r_out_phase  <= r_phase;
            r_out_last   <= r_last;
            r_out_low    <= r_low;
            r_out_high   <= r_high;
            r_out_total  <= r_sc;
        end
    end

    assign o_stat.skip     = (r_op == OP_RESTART) || !r_has;
    assign o_stat.phase    = r_phase;
    assign o_stat.cal_hit  = w_cal_hit;
    assign o_stat.div_done = (r_cnt == CNT_LAST);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_phase           = r_out_phase;
    assign o_last_ratio      = r_out_last;
    assign o_lowest_ratio    = r_out_low;
    assign o_highest_ratio   = r_out_high;
    assign o_total_commanded = r_out_total;

endmodule
